FILE: hdl/vision_frame_receiver_core_macros.svh
// ----------------------------------------------------------------------------
// vision_frame_receiver_core assertion macros
// Implication and next-cycle checks, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VISION_FRAME_RECEIVER_CORE_MACROS_SVH
`define VISION_FRAME_RECEIVER_CORE_MACROS_SVH
`ifndef SYNTH
`define VFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("vfr check failed");
`define VFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("vfr check failed");
`else
`define VFR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/vfr_pkg.sv
// ----------------------------------------------------------------------------
// vfr_pkg
// Shared constants and the frame word passed from parser to decoder.
// ----------------------------------------------------------------------------
package vfr_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int WIN_LEN         = 5;

	localparam logic [7:0] HDR_BYTE        = 8'hAA;
	localparam logic [7:0] BAD_FUNC        = 8'hFF;
	localparam logic [7:0] CODE_DOT_LINE   = 8'hF2;
	localparam logic [7:0] CODE_LINE       = 8'hF3;
	localparam logic [7:0] CODE_LINE_POINT = 8'hF4;

	localparam logic [1:0] KIND_DOT_LINE   = 2'd0;
	localparam logic [1:0] KIND_LINE       = 2'd1;
	localparam logic [1:0] KIND_LINE_POINT = 2'd2;
	localparam logic [1:0] KIND_OTHER      = 2'd3;

	typedef struct packed {
		logic [1:0]                kind;
		logic [WIN_LEN-1:0][7:0]   win;
	} frame_t;

endpackage

FILE: hdl/vfr_front.sv
// ----------------------------------------------------------------------------
// vfr_front
// Byte parser: header hunt, length count, window capture, frame classify.
// ----------------------------------------------------------------------------
module vfr_front #(
	parameter int MAX_PAYLOAD = vfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      rx_byte,
	output logic            push,
	output vfr_pkg::frame_t frame
);
	import vfr_pkg::*;

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

	localparam logic [2:0] PH_HDR1  = 3'd0;
	localparam logic [2:0] PH_HDR2  = 3'd1;
	localparam logic [2:0] PH_FUNC  = 3'd2;
	localparam logic [2:0] PH_LEN   = 3'd3;
	localparam logic [2:0] PH_PAY   = 3'd4;
	localparam logic [2:0] PH_TRAIL = 3'd5;

	logic [2:0]              phase_q, phase_d;
	logic [LEN_W-1:0]        rem_q, rem_d;
	logic [LEN_W-1:0]        idx_q, idx_d;
	logic [7:0]              func_q, func_d;
	logic [WIN_LEN-1:0][7:0] win_q, win_d;
	logic                    in_win;

	assign in_win = (idx_q < LEN_W'(WIN_LEN));

	always_comb begin
		phase_d = phase_q;
		rem_d   = rem_q;
		idx_d   = idx_q;
		func_d  = func_q;
		win_d   = win_q;
		push    = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_HDR1: begin
					phase_d = (rx_byte == HDR_BYTE) ? PH_HDR2 : PH_HDR1;
				end
				PH_HDR2: begin
					phase_d = (rx_byte == HDR_BYTE) ? PH_FUNC : PH_HDR1;
				end
				PH_FUNC: begin
					if (rx_byte != BAD_FUNC) begin
						func_d  = rx_byte;
						phase_d = PH_LEN;
					end else begin
						phase_d = PH_HDR1;
					end
				end
				PH_LEN: begin
					if (rx_byte <= 8'(MAX_PAYLOAD)) begin
						rem_d   = rx_byte[LEN_W-1:0];
						idx_d   = '0;
						phase_d = PH_PAY;
					end else begin
						phase_d = PH_HDR1;
					end
				end
				PH_PAY: begin
					// zero length: this byte aborts the frame
					if (rem_q != '0) begin
						rem_d = rem_q - LEN_W'(1);
						if (in_win)
							win_d[idx_q[2:0]] = rx_byte;
						idx_d = idx_q + LEN_W'(1);
						if (rem_q == LEN_W'(1))
							phase_d = PH_TRAIL;
					end else begin
						phase_d = PH_HDR1;
					end
				end
				PH_TRAIL: begin
					phase_d = PH_HDR1;
					if (in_win)
						win_d[idx_q[2:0]] = rx_byte;
					push = 1'b1;
				end
				default: begin
					phase_d = PH_HDR1;
				end
			endcase
		end
	end

	always_comb begin
		frame.win = win_d;
		case (func_q)
			CODE_DOT_LINE:   frame.kind = KIND_DOT_LINE;
			CODE_LINE:       frame.kind = KIND_LINE;
			CODE_LINE_POINT: frame.kind = KIND_LINE_POINT;
			default:         frame.kind = KIND_OTHER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR1;
			rem_q   <= '0;
			idx_q   <= '0;
			func_q  <= '0;
			win_q   <= '0;
		end else begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			idx_q   <= idx_d;
			func_q  <= func_d;
			win_q   <= win_d;
		end
	end

endmodule

FILE: hdl/vfr_queue.sv
// ----------------------------------------------------------------------------
// vfr_queue
// Two-entry frame queue between parser and decoder.
// ----------------------------------------------------------------------------
module vfr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vfr_pkg::frame_t din,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output vfr_pkg::frame_t dout
);
	import vfr_pkg::*;

	`include "vision_frame_receiver_core_macros.svh"

	frame_t     ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign dout  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`VFR_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full)
	`VFR_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, valid)
	`VFR_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= 2'd2)
	`VFR_ASSERT_NEXT(a_push_lands, clk, arst_n, push && !pop, valid)

endmodule

FILE: hdl/vfr_back.sv
// ----------------------------------------------------------------------------
// vfr_back
// Frame decoder: updates the held record and presents it as the output word.
// ----------------------------------------------------------------------------
module vfr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  vfr_pkg::frame_t    q_frame,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [1:0]  frame_kind,
	output logic        [7:0]  dot_flag,
	output logic        [7:0]  line_flag,
	output logic signed [15:0] angle_x,
	output logic signed [15:0] angle_y,
	output logic signed [15:0] tag_x,
	output logic signed [15:0] cross_x
);
	import vfr_pkg::*;

	`include "vision_frame_receiver_core_macros.svh"

	logic               out_valid_q;
	logic        [1:0]  kind_q;
	logic        [7:0]  dot_q, line_q;
	logic signed [15:0] ax_q, ay_q, tx_q, cx_q;

	// the held record doubles as the output register
	assign pop        = q_valid && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign frame_kind = kind_q;
	assign dot_flag   = dot_q;
	assign line_flag  = line_q;
	assign angle_x    = ax_q;
	assign angle_y    = ay_q;
	assign tag_x      = tx_q;
	assign cross_x    = cx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kind_q      <= KIND_DOT_LINE;
			dot_q       <= '0;
			line_q      <= '0;
			ax_q        <= '0;
			ay_q        <= '0;
			tx_q        <= '0;
			cx_q        <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				kind_q      <= q_frame.kind;
				case (q_frame.kind)
					KIND_DOT_LINE, KIND_LINE: begin
						if (q_frame.kind == KIND_DOT_LINE)
							dot_q <= q_frame.win[0];
						line_q <= q_frame.win[4];
						ax_q   <= {q_frame.win[0], q_frame.win[1]};
						ay_q   <= {q_frame.win[2], q_frame.win[3]};
					end
					KIND_LINE_POINT: begin
						line_q <= q_frame.win[0];
						tx_q   <= {q_frame.win[1], q_frame.win[2]};
						cx_q   <= {q_frame.win[3], q_frame.win[4]};
					end
					default: begin
					end
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`VFR_ASSERT_NEXT(a_load_shows, clk, arst_n, pop, out_valid)
	`VFR_ASSERT_NEXT(a_hold_stall, clk, arst_n, out_valid && !out_ready, out_valid)
	`VFR_ASSERT_NEXT(a_drain, clk, arst_n, out_valid && out_ready && !pop, !out_valid)

endmodule

FILE: hdl/vision_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// vision_frame_receiver_core
// Camera link frame parser: one byte per word in, one decoded record per frame.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    rx_byte
//   out      out  out_valid/out_ready  frame_kind, dot_flag, line_flag,
//                                      angle_x, angle_y, tag_x, cross_x
//
// One byte per cycle while in_ready is high; a frame's record is written into
// the frame queue when its trailing byte is taken, then decoded into the output
// register once the output side can take it.
// in_ready drops only while the two-entry frame queue is full.
// Output stalls back up into the queue, then into the input.
// Reset clears the parser, the byte window and the held record.
// ----------------------------------------------------------------------------
module vision_frame_receiver_core #(
	parameter int MAX_PAYLOAD = vfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [7:0]  rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [1:0]  frame_kind,
	output logic        [7:0]  dot_flag,
	output logic        [7:0]  line_flag,
	output logic signed [15:0] angle_x,
	output logic signed [15:0] angle_y,
	output logic signed [15:0] tag_x,
	output logic signed [15:0] cross_x
);
	import vfr_pkg::*;

	logic   accept;
	logic   push;
	logic   q_full;
	logic   q_valid;
	logic   pop;
	frame_t push_frame;
	frame_t q_frame;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	vfr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.push    (push),
		.frame   (push_frame)
	);

	vfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_frame),
		.full   (q_full),
		.pop    (pop),
		.valid  (q_valid),
		.dout   (q_frame)
	);

	vfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_frame    (q_frame),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_kind (frame_kind),
		.dot_flag   (dot_flag),
		.line_flag  (line_flag),
		.angle_x    (angle_x),
		.angle_y    (angle_y),
		.tag_x      (tag_x),
		.cross_x    (cross_x)
	);

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vision_frame_receiver_core. It feeds received bytes
// through the input word channel and checks each decoded record against an
// in-bench frame parser. It runs a short table of header and length corner
// cases first, then random frames mixed with line noise and broken headers,
// with random idling on both channels, one long output stall and periodic
// drains.
// ----------------------------------------------------------------------------
module tb_top;
	import vfr_pkg::*;

	localparam int N_ITEMS = 1350;
	localparam int N_DIR   = 30;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         dot;
		logic [7:0]         line;
		logic signed [15:0] ang_x;
		logic signed [15:0] ang_y;
		logic signed [15:0] tag_pos;
		logic signed [15:0] crs_pos;
	} rec_t;

	typedef struct packed {
		logic [7:0] b;
		logic       has_rec;
		rec_t       rec;
	} dir_row_t;

	typedef enum logic [2:0] {
		PH_HDR1, PH_HDR2, PH_FUNC, PH_LEN, PH_BODY, PH_TRAIL
	} phase_e;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic        [7:0]  rx_byte   = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic        [1:0]  frame_kind;
	logic        [7:0]  dot_flag;
	logic        [7:0]  line_flag;
	logic signed [15:0] angle_x;
	logic signed [15:0] angle_y;
	logic signed [15:0] tag_x;
	logic signed [15:0] cross_x;

	// Idling controls shared by the sender, the receiver and the main sequence
	bit src_fast  = 1'b0;
	bit sink_fast = 1'b0;
	bit sink_hold = 1'b0;

	int n_fed  = 0;
	int n_good = 0;
	int n_chk  = 0;
	int n_err  = 0;
	int kind_cnt [4] = '{default: 0};

	// Parser model state
	phase_e     ph       = PH_HDR1;
	logic [5:0] left_cnt = '0;
	logic [5:0] widx     = '0;
	logic [7:0] fcode    = '0;
	logic [7:0] win [WIN_LEN] = '{default: 8'h00};
	rec_t       held     = '0;
	rec_t       rec_q [$];

	// Corner cases; typed records are the ones that are obvious from reset
	dir_row_t dir_tab [N_DIR] = '{
		'{8'hAA, 1'b0, '0}, '{8'h12, 1'b0, '0},                       // bad second header
		'{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'hFF, 1'b0, '0},   // function 0xFF
		'{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'hF3, 1'b0, '0},
		'{8'h21, 1'b0, '0},                                           // length above max
		'{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'hF3, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'hAA, 1'b0, '0},                       // zero length, AA dropped
		'{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'hF2, 1'b0, '0},
		'{8'h05, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'h01, 1'b0, '0},
		'{8'h7F, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'h33, 1'b1, '{KIND_DOT_LINE, 8'h80, 8'hFF, 16'sh8001, 16'sh7FFF, 16'sh0, 16'sh0}},
		// one-byte point frame: trailer lands in w[1], w[2..4] are stale
		'{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'hF4, 1'b0, '0},
		'{8'h01, 1'b0, '0}, '{8'hC3, 1'b0, '0}, '{8'h7E, 1'b0, '0}
	};

	vision_frame_receiver_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_kind (frame_kind),
		.dot_flag   (dot_flag),
		.line_flag  (line_flag),
		.angle_x    (angle_x),
		.angle_y    (angle_y),
		.tag_x      (tag_x),
		.cross_x    (cross_x)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Advance the parser model by one byte; done is set when a frame closes
	task automatic parse_byte(input logic [7:0] b, output logic done, output rec_t r);
		done = 1'b0;
		case (ph)
			PH_HDR1: ph = (b == HDR_BYTE) ? PH_HDR2 : PH_HDR1;
			PH_HDR2: ph = (b == HDR_BYTE) ? PH_FUNC : PH_HDR1;
			PH_FUNC: begin
				if (b != BAD_FUNC) begin
					fcode = b;
					ph    = PH_LEN;
				end else begin
					ph = PH_HDR1;
				end
			end
			PH_LEN: begin
				if (b <= MAX_PAYLOAD_DEF) begin
					left_cnt = b[5:0];
					widx     = '0;
					ph       = PH_BODY;
				end else begin
					ph = PH_HDR1;
				end
			end
			PH_BODY: begin
				// zero length lands here with nothing left: byte dropped
				if (left_cnt != 0) begin
					left_cnt--;
					if (widx < WIN_LEN)
						win[widx] = b;
					widx++;
					if (left_cnt == 0)
						ph = PH_TRAIL;
				end else begin
					ph = PH_HDR1;
				end
			end
			PH_TRAIL: begin
				ph = PH_HDR1;
				if (widx < WIN_LEN)
					win[widx] = b;
				if (fcode == CODE_DOT_LINE || fcode == CODE_LINE) begin
					held.kind = (fcode == CODE_DOT_LINE) ? KIND_DOT_LINE : KIND_LINE;
					if (fcode == CODE_DOT_LINE)
						held.dot = win[0];
					held.line  = win[4];
					held.ang_x = {win[0], win[1]};
					held.ang_y = {win[2], win[3]};
				end else if (fcode == CODE_LINE_POINT) begin
					held.kind    = KIND_LINE_POINT;
					held.line    = win[0];
					held.tag_pos = {win[1], win[2]};
					held.crs_pos = {win[3], win[4]};
				end else begin
					held.kind = KIND_OTHER;
				end
				done = 1'b1;
			end
			default: ph = PH_HDR1;
		endcase
		r = held;
	endtask

	// One input word: random gap, then hold valid until taken
	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = src_fast ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte  = b;
		do @(posedge clk); while (!in_ready);
		n_fed++;
	endtask

	task automatic feed(input logic [7:0] b);
		logic done;
		rec_t r;
		push_byte(b);
		parse_byte(b, done, r);
		if (done)
			rec_q.push_back(r);
	endtask

	function automatic logic [7:0] body_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			4: return HDR_BYTE;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_code();
		case ($urandom_range(0, 9))
			0, 1, 2: return CODE_DOT_LINE;
			3, 4, 5: return CODE_LINE;
			6, 7, 8: return CODE_LINE_POINT;
			default: return 8'($urandom_range(0, 254));
		endcase
	endfunction

	function automatic int pick_len();
		case ($urandom_range(0, 15))
			0: return MAX_PAYLOAD_DEF;
			1: return 0;
			2, 3: return $urandom_range(6, MAX_PAYLOAD_DEF - 1);
			default: return $urandom_range(1, 5);
		endcase
	endfunction

	task automatic send_frame(input logic [7:0] code, input int len);
		feed(HDR_BYTE);
		feed(HDR_BYTE);
		feed(code);
		feed(8'(len));
		for (int i = 0; i < len; i++)
			feed(body_byte());
		feed(8'($urandom));
		n_good += len + 5;
	endtask

	// Stop sending until every pending record has come out
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (rec_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic chk(input string fname, input int e, input int a);
		if (e != a) begin
			$error("%s: expected %0d, got %0d", fname, e, a);
			n_err++;
		end
	endtask

	always @(posedge clk) begin
		rec_t e;
		if (arst_n && out_valid && out_ready) begin
			if (rec_q.size() == 0) begin
				$error("frame_kind: expected no record, got %0d", frame_kind);
				n_err++;
			end else begin
				e = rec_q.pop_front();
				kind_cnt[e.kind]++;
				n_chk++;
				chk("frame_kind", e.kind, frame_kind);
				chk("dot_flag", e.dot, dot_flag);
				chk("line_flag", e.line, line_flag);
				chk("angle_x", e.ang_x, angle_x);
				chk("angle_y", e.ang_y, angle_y);
				chk("tag_x", e.tag_pos, tag_x);
				chk("cross_x", e.crs_pos, cross_x);
			end
		end
	end

	// Output side: random stall per word, plus one long hold on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				sink_hold = 1'b0;
			end
			gap = sink_fast ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid && !sink_hold);
		end
	end

	initial begin
		logic done;
		rec_t r;
		int   next_drain;
		bit   pressed;
		pressed    = 1'b0;
		next_drain = 250;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIR; i++) begin
			push_byte(dir_tab[i].b);
			parse_byte(dir_tab[i].b, done, r);
			if (done)
				rec_q.push_back(dir_tab[i].has_rec ? dir_tab[i].rec : r);
		end
		drain();

		while (n_good < N_ITEMS) begin
			if ($urandom_range(0, 39) == 0) begin
				src_fast  = ($urandom_range(0, 2) == 0);
				sink_fast = ($urandom_range(0, 2) == 0);
			end
			if (!pressed && n_good >= 500) begin
				// frames keep coming while the output is held; queue fills, in_ready drops
				pressed   = 1'b1;
				sink_hold = 1'b1;
				src_fast  = 1'b1;
				repeat (10) send_frame(pick_code(), $urandom_range(1, 3));
				src_fast = 1'b0;
				drain();
			end
			if (n_good >= next_drain) begin
				drain();
				next_drain += 250;
			end
			case ($urandom_range(0, 15))
				0: feed(8'($urandom));
				1: begin
					feed(HDR_BYTE);
					feed(8'($urandom));
				end
				2: begin
					feed(HDR_BYTE);
					feed(HDR_BYTE);
					feed(BAD_FUNC);
				end
				3: begin
					feed(HDR_BYTE);
					feed(HDR_BYTE);
					feed(pick_code());
					feed(8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)));
				end
				default: send_frame(pick_code(), pick_len());
			endcase
		end
		drain();
		repeat (10) @(posedge clk);

		$display("tb: %0d bytes sent, %0d records checked, %0d mismatches",
			n_fed, n_chk, n_err);
		$display("tb: kinds seen dot+line %0d, line %0d, line+point %0d, other %0d",
			kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3]);
		if (n_err == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
